FILE: src/mdac_pkg.sv
`timescale 1ns / 1ps

package mdac_pkg;

    // table geometry
    localparam int NUM_ARRAYS = 16;
    localparam int MAX_DIMS   = 16;
    localparam int ARR_W      = $clog2(NUM_ARRAYS);
    localparam int DIM_W      = $clog2(MAX_DIMS);
    localparam int SLOTS      = NUM_ARRAYS * MAX_DIMS;
    localparam int SLOT_W     = ARR_W + DIM_W;

    // payload widths
    localparam int ID_W   = 4;
    localparam int POS_W  = 4;
    localparam int DATA_W = 32;
    localparam int DCNT_W = 5;

    typedef enum logic [1:0] {
        OP_HDR = 2'd0,
        OP_BND = 2'd1,
        OP_QRY = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [ID_W-1:0]          array_id;
        logic [POS_W-1:0]         dim_pos;
        logic signed [DATA_W-1:0] value_a;
        logic signed [DATA_W-1:0] value_b;
        logic [DCNT_W-1:0]        dim_count;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]          array_tag;
        logic signed [DATA_W-1:0] address;
    } t_out;

    // descriptor header entry
    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] esz;
        logic [DCNT_W-1:0] dims;
    } t_desc;

    // per-dimension bounds entry
    typedef struct packed {
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
    } t_bnd;

endpackage

FILE: src/multidim_array_address_calc.sv
`timescale 1ns / 1ps

// Row-major array address calculator with per-dimension lower bounds.
// Input channel: i_in is taken at a rising edge with start high and busy low.
//   op HDR loads base, element size and dimension count of one array;
//   op BND loads lower/upper bound of one dimension; op QRY streams one
//   index of a query, in dimension order, with last on the final index.
// Loads never raise busy.
// A query index item raises busy after its beat, in S_MUL (descriptor and
//   bounds memory read, then multiply), and drops it in S_ADD (accumulate),
//   so the next index is taken only then, overlapping the accumulate.
// The last index keeps busy through S_ADD and adds a scale multiply (S_SCALE)
//   and the base add (S_FIN): o_strobe with o_out rises after S_FIN, and the
//   next input beat is taken at the same edge as the result beat.
// Each result is shown for exactly one cycle; the receiver cannot stall.
// The rate is set by the 32x32 multiply, registered before the
//   accumulate, and by the registered read of the tables.
// Reset (synchronous, active low) clears the running offset, the index
//   position and the sequencer; the tables are not cleared and must be
//   loaded before a query reads them.
module multidim_array_address_calc
    import mdac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_strobe,
    output t_out o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_ADD   = 5'b00100,
        S_SCALE = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // table memories
    t_desc desc_mem [NUM_ARRAYS];
    t_bnd  bnd_mem  [SLOTS];

    t_desc r_desc_rd;
    t_bnd  r_bnd_rd;
    logic  r_arr_ok;

    // query datapath
    logic [DATA_W-1:0] r_acc;
    logic [DIM_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_diff;
    logic [DATA_W-1:0] r_va;
    logic [ID_W-1:0]   r_tag;
    logic              r_last;
    logic              r_strobe;
    t_out              r_out;

    logic              w_accept;
    logic              w_qry;
    logic              w_arr_ok;
    logic [DATA_W-1:0] w_lo;
    logic [DATA_W-1:0] w_hi;
    logic [DATA_W-1:0] w_base;
    logic [DATA_W-1:0] w_esz;
    logic [DATA_W-1:0] w_span;
    logic [SLOT_W-1:0] w_wr_slot;
    logic [SLOT_W-1:0] w_rd_slot;

    // handshake
    assign busy     = (r_state inside {S_MUL, S_SCALE, S_FIN})
                   || ((r_state == S_ADD) && r_last);
    assign w_accept = start && !busy;
    assign w_qry    = (i_in.op == OP_QRY);
    assign w_arr_ok = ({{(32-ID_W){1'b0}}, i_in.array_id} < NUM_ARRAYS);

    assign w_wr_slot = {i_in.array_id[ARR_W-1:0], i_in.dim_pos[DIM_W-1:0]};
    assign w_rd_slot = {i_in.array_id[ARR_W-1:0], r_idx};

    // out-of-range ids read as zero
    assign w_lo   = r_arr_ok ? r_bnd_rd.lower : '0;
    assign w_hi   = r_arr_ok ? r_bnd_rd.upper : '0;
    assign w_base = r_arr_ok ? r_desc_rd.base : '0;
    assign w_esz  = r_arr_ok ? r_desc_rd.esz  : '0;
    assign w_span = w_hi - w_lo + DATA_W'(1);

    // descriptor memory: write on header beat, read on query beat
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.op == OP_HDR) && w_arr_ok) begin
            desc_mem[i_in.array_id[ARR_W-1:0]] <= '{base: i_in.value_a,
                                                    esz:  i_in.value_b,
                                                    dims: i_in.dim_count};
        end
        if (w_accept && w_qry) begin
            r_desc_rd <= desc_mem[i_in.array_id[ARR_W-1:0]];
        end
    end

    // bounds memory: write on bounds beat, read at current dimension
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.op == OP_BND) && w_arr_ok
            && ({{(32-POS_W){1'b0}}, i_in.dim_pos} < MAX_DIMS)) begin
            bnd_mem[w_wr_slot] <= '{lower: i_in.value_a, upper: i_in.value_b};
        end
        if (w_accept && w_qry) begin
            r_bnd_rd <= bnd_mem[w_rd_slot];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_qry) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_last)                n_state = S_SCALE;
                else if (w_accept && w_qry) n_state = S_MUL;
                else                       n_state = S_IDLE;
            end
            S_SCALE: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_FIN);
            if (r_state == S_ADD) begin
                r_acc <= r_prod + r_diff;
            end else if (r_state == S_SCALE) begin
                r_acc <= '0;
            end
            if (w_accept && w_qry) begin
                if (i_in.last || (r_idx == DIM_W'(MAX_DIMS - 1))) r_idx <= '0;
                else                                               r_idx <= r_idx + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept && w_qry) begin
            r_va     <= i_in.value_a;
            r_tag    <= i_in.array_id;
            r_last   <= i_in.last;
            r_arr_ok <= w_arr_ok;
        end
        case (r_state)
            S_MUL: begin
                r_prod <= r_acc * w_span;
                r_diff <= r_va - w_lo;
            end
            S_SCALE: begin
                r_prod <= r_acc * w_esz;
            end
            S_FIN: begin
                r_out.array_tag <= r_tag;
                r_out.address   <= w_base + r_prod;
            end
            default: begin
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // checks
    a_strobe_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_FIN))
        else $error("strobe without finishing step");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result beat longer than one cycle");

    a_query_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_acc == '0) && (r_idx == '0))
        else $error("query state not cleared after result");

    a_last_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_in.op == OP_QRY) && i_in.last) |-> ##5 o_strobe)
        else $error("last index did not yield a result on time");

endmodule
